// File: src/tfoe_pkg.sv
package tfoe_pkg;

  // converter frame layout
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned CODE_LSB = 3;

  // sample and register widths
  localparam int unsigned SAMPLE_W       = 14;
  localparam int unsigned OFFSET_W       = 10;
  localparam int unsigned MAX_REL_W      = 8;
  localparam int unsigned SHIFT_W        = 3;
  localparam int unsigned REL_SCALE_BITS = 8;

  // filter fraction bits below the quarter degree
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // register reset values
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST  = '0;
  localparam logic [MAX_REL_W-1:0]       MAX_REL_RST = 8'd26;
  localparam logic [SHIFT_W-1:0]         SHIFT_RST   = 3'd3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET    = 2'd0,
    CFG_MAX_REL   = 2'd1,
    CFG_AVG_SHIFT = 2'd2
  } cfg_idx_e;

  // live configuration
  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic [MAX_REL_W-1:0]       max_rel;
    logic [SHIFT_W-1:0]         avg_shift;
  } cfg_t;

  // filter status
  typedef struct packed {
    logic primed;
  } flt_status_t;

endpackage

// File: src/tfoe_cfg.sv
module tfoe_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tfoe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tfoe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output tfoe_pkg::cfg_t                      cfg_o
);
  import tfoe_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register decode, unknown index leaves everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET:    cfg_d.offset    = $signed(cfg_data_i[OFFSET_W-1:0]);
        CFG_MAX_REL:   cfg_d.max_rel   = cfg_data_i[MAX_REL_W-1:0];
        CFG_AVG_SHIFT: cfg_d.avg_shift = cfg_data_i[SHIFT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset    <= OFFSET_RST;
      cfg_q.max_rel   <= MAX_REL_RST;
      cfg_q.avg_shift <= SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/tfoe_front.sv
module tfoe_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [tfoe_pkg::OFFSET_W-1:0] offset_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tfoe_pkg::FRAME_W-1:0]         raw_frame_i,
  output logic                                 smp_valid_o,
  input  logic                                 smp_ready_i,
  output logic signed [tfoe_pkg::SAMPLE_W-1:0] smp_o
);
  import tfoe_pkg::*;

  logic [CODE_W-1:0]          code;
  logic signed [SAMPLE_W-1:0] code_ext;
  logic signed [SAMPLE_W-1:0] off_ext;
  logic signed [SAMPLE_W-1:0] smp_d, smp_q;
  logic                       valid_d, valid_q;
  logic                       take;

  // code extraction and calibration offset
  assign code     = raw_frame_i[CODE_LSB +: CODE_W];
  assign code_ext = $signed(SAMPLE_W'(code));
  assign off_ext  = SAMPLE_W'(offset_i);
  assign smp_d    = code_ext + off_ext;

  // stage moves when empty or when the filter takes its item
  assign in_ready_o = !valid_q || smp_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      smp_q <= smp_d;
    end
  end

  assign smp_valid_o = valid_q;
  assign smp_o       = smp_q;

endmodule

// File: src/tfoe_filter.sv
module tfoe_filter #(
  parameter int unsigned FRACTION_BITS = tfoe_pkg::FRACTION_BITS_DEF,
  parameter int unsigned FILT_W        = tfoe_pkg::SAMPLE_W + FRACTION_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tfoe_pkg::cfg_t                        cfg_i,
  input  logic                                  smp_valid_i,
  output logic                                  smp_ready_o,
  input  logic signed [tfoe_pkg::SAMPLE_W-1:0]  smp_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tfoe_pkg::SAMPLE_W-1:0]  sample_temp_o,
  output logic signed [FILT_W-1:0]              filtered_temp_o,
  output logic                                  sample_accepted_o,
  output tfoe_pkg::flt_status_t                 status_o
);
  import tfoe_pkg::*;

  localparam int unsigned LHS_W = FILT_W + 1 + REL_SCALE_BITS;
  localparam int unsigned RHS_W = FILT_W + MAX_REL_W;

  logic signed [FILT_W-1:0]   filt_q, filt_d;
  logic                       primed_q, primed_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] smp_out_q;
  logic signed [FILT_W-1:0]   filt_out_q;
  logic                       acc_q, acc_d;
  logic                       take;

  logic signed [FILT_W-1:0]   scaled;
  logic signed [FILT_W:0]     diff;
  logic [FILT_W:0]            abs_d;
  logic [FILT_W-1:0]          abs_f;
  logic [LHS_W-1:0]           lhs;
  logic [RHS_W-1:0]           rhs;
  logic                       in_limit;
  logic signed [FILT_W:0]     step;

  // result register frees up when empty or taken
  assign smp_ready_o = !out_valid_q || out_ready_i;
  assign take        = smp_valid_i && smp_ready_o;

  // sample moved onto the filter grid
  assign scaled = FILT_W'(smp_i) <<< FRACTION_BITS;
  assign diff   = {scaled[FILT_W-1], scaled} - {filt_q[FILT_W-1], filt_q};
  assign abs_d  = diff[FILT_W] ? (FILT_W + 1)'(-diff) : diff;
  assign abs_f  = filt_q[FILT_W-1] ? FILT_W'(-filt_q) : filt_q;

  // relative change test without a divide
  assign lhs      = {abs_d, {REL_SCALE_BITS{1'b0}}};
  assign rhs      = RHS_W'(abs_f) * RHS_W'(cfg_i.max_rel);
  assign in_limit = lhs < LHS_W'(rhs);
  assign step     = diff >>> cfg_i.avg_shift;

  // load on first item, otherwise move toward the sample when in limit
  always_comb begin
    filt_d   = filt_q;
    primed_d = primed_q;
    acc_d    = 1'b0;
    if (!primed_q) begin
      filt_d   = scaled;
      primed_d = 1'b1;
      acc_d    = 1'b1;
    end else if (in_limit) begin
      filt_d = filt_q + step[FILT_W-1:0];
      acc_d  = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (smp_ready_o) begin
      out_valid_d = smp_valid_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        filt_q   <= filt_d;
        primed_q <= primed_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      smp_out_q  <= smp_i;
      filt_out_q <= filt_d;
      acc_q      <= acc_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_temp_o     = smp_out_q;
  assign filtered_temp_o   = filt_out_q;
  assign sample_accepted_o = acc_q;
  assign status_o.primed   = primed_q;

endmodule

// File: src/thermocouple_frame_outlier_ema.sv
// Thermocouple frame filter with outlier rejection.
// Input channel (in_valid_i / in_ready_o) carries one 16-bit converter frame
// per item; the 12-bit quarter-degree code sits in bits 14 to 3. Output
// channel (out_valid_o / out_ready_i) returns one result per item: the
// offset-corrected sample, the filter value after the item and a flag that
// says whether the sample loaded or moved the filter.
// An accepted frame sits in the sample register, moves into the result
// register when the filter takes it, and its result is taken from there.
// Throughput: one item per cycle while out_ready_i stays high; the relative
// change compare (one 8-bit by filter-width multiply) and the shift-add are
// combinational between the sample register and the result register.
// Configuration writes (cfg_valid_i / cfg_ready_o, always ready) go to
// offset, relative change limit and averaging shift; write them while idle.
// Reset: registers return to offset 0, limit 26/256, shift 3, and the
// filter is unprimed so the next sample loads it.
// Receiver stall: the result register holds, the sample stage fills, and
// in_ready_o then drops until out_ready_i returns.
module thermocouple_frame_outlier_ema #(
  parameter int unsigned FRACTION_BITS = tfoe_pkg::FRACTION_BITS_DEF,
  parameter int unsigned FILT_W        = tfoe_pkg::SAMPLE_W + FRACTION_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tfoe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tfoe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tfoe_pkg::FRAME_W-1:0]         raw_frame_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tfoe_pkg::SAMPLE_W-1:0] sample_temp_o,
  output logic signed [FILT_W-1:0]             filtered_temp_o,
  output logic                                 sample_accepted_o
);
  import tfoe_pkg::*;

  cfg_t                       cfg;
  flt_status_t                status;
  logic                       smp_valid;
  logic                       smp_ready;
  logic signed [SAMPLE_W-1:0] smp;

  // configuration registers
  tfoe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // frame decode and sample register
  tfoe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .offset_i    (cfg.offset),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_frame_i (raw_frame_i),
    .smp_valid_o (smp_valid),
    .smp_ready_i (smp_ready),
    .smp_o       (smp)
  );

  // filter state and result register
  tfoe_filter #(
    .FRACTION_BITS (FRACTION_BITS),
    .FILT_W        (FILT_W)
  ) u_filter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .smp_valid_i       (smp_valid),
    .smp_ready_o       (smp_ready),
    .smp_i             (smp),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sample_temp_o     (sample_temp_o),
    .filtered_temp_o   (filtered_temp_o),
    .sample_accepted_o (sample_accepted_o),
    .status_o          (status)
  );

  // input never stalls while the result register is empty
  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty result register");

  // a rejected sample only happens once the filter is loaded
  a_reject_needs_primed : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_accepted_o) |-> status.primed
  ) else $error("sample rejected before filter was loaded");

  // the loading item reports its own sample as the filter value
  a_load_value : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(status.primed) |->
      (out_valid_o && sample_accepted_o &&
       filtered_temp_o == (FILT_W'(sample_temp_o) <<< FRACTION_BITS))
  ) else $error("filter load value mismatch");

  // once loaded the filter stays loaded
  a_primed_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    status.primed |=> status.primed
  ) else $error("filter lost its primed state");

endmodule
